// ----- rtl/espml_pkg.sv -----
// Shared types, constants and command codes for the encoder speed PID loop.
package espml_pkg;

    localparam int ANGLE_W = 12;
    localparam int DT_W    = 24;
    localparam int SPEED_W = 16;
    localparam int DUTY_W  = 8;
    localparam int ERR_W   = 17;
    localparam int INTEG_W = 32;
    localparam int GAIN_W  = 32;
    localparam int OP_W    = 33;
    localparam int PROD_W  = 66;
    localparam int SUM_W   = 56;
    localparam int DIV_W   = 50;
    localparam int CNT_W   = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [15:0]    RPM_SCALE     = 16'd14653;
    localparam logic [CNT_W-1:0] SPD_DIV_STEPS = CNT_W'(26);
    localparam logic [CNT_W-1:0] D_DIV_STEPS   = CNT_W'(DIV_W);

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_RPM  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_EMA_ALPHA   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STILL_THR   = 3'd6;

    typedef struct packed {
        logic [SPEED_W-1:0] target_rpm;
        logic [GAIN_W-1:0]  prop_gain;
        logic [GAIN_W-1:0]  integ_gain;
        logic [GAIN_W-1:0]  deriv_gain;
        logic [7:0]         integ_limit;
        logic [8:0]         ema_alpha;
        logic [ANGLE_W-1:0] still_threshold;
    } cfg_t;

    typedef enum logic [2:0] {
        MUL_SCALE,
        MUL_ALPHA,
        MUL_BETA,
        MUL_INTEG,
        MUL_PROP,
        MUL_IGAIN,
        MUL_DERIV
    } mul_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_DLOAD_SPD,
        S_DIV_SPD,
        S_EMA_A,
        S_EMA_B,
        S_EMA_C,
        S_MUL_INT,
        S_INT,
        S_P,
        S_I,
        S_DLOAD_D,
        S_DIV_D,
        S_D,
        S_FIN
    } state_t;

    typedef struct packed {
        mul_sel_t mul_sel;
        logic     load_in;
        logic     check;
        logic     div_load_spd;
        logic     div_load_d;
        logic     div_step;
        logic     ema_b;
        logic     ema_c;
        logic     int_latch;
        logic     p_latch;
        logic     i_add;
        logic     d_add;
        logic     commit;
    } cmd_t;

    typedef struct packed {
        logic still;
    } stat_t;

endpackage

// ----- rtl/espml_if.sv -----
// Valid/ready channel interfaces for sample items and result items.
interface espml_sample_if;
    logic                            valid;
    logic                            ready;
    logic [espml_pkg::ANGLE_W-1:0]   angle_raw;
    logic [espml_pkg::DT_W-1:0]      elapsed_us;

    modport source (output valid, output angle_raw, output elapsed_us, input ready);
    modport sink   (input valid, input angle_raw, input elapsed_us, output ready);
endinterface

interface espml_result_if;
    logic                            valid;
    logic                            ready;
    logic [espml_pkg::DUTY_W-1:0]    motor_duty;
    logic [espml_pkg::SPEED_W-1:0]   speed_rpm;

    modport source (output valid, output motor_duty, output speed_rpm, input ready);
    modport sink   (input valid, input motor_duty, input speed_rpm, output ready);
endinterface

// ----- rtl/encoder_speed_pid_motor_loop.sv -----
// Top level: configuration registers, controller and datapath of the speed PID loop.
//
//  channel  dir  handshake           payload
//  sample   in   valid/ready         angle_raw[11:0], elapsed_us[23:0]
//  result   out  valid/ready         motor_duty[7:0], speed_rpm[15:0]
//  cfg      in   cfg_we              cfg_index[2:0], cfg_wdata[31:0]
//
// The serial divider runs 26 steps for speed and 50 for the derivative term; the
// speed divide is skipped when the angle is still.
// One item is in work at a time; the next is taken while the last result waits.
// Reset clears loop state and loads the default gains; a stalled result holds the
// final step until the output register frees.
module encoder_speed_pid_motor_loop (
    input  logic                                clk,
    input  logic                                rst_n,
    espml_sample_if.sink                        sample,
    espml_result_if.source                      result,
    input  logic                                cfg_we,
    input  logic [espml_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [espml_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    espml_pkg::cfg_t  cfg_reg;
    espml_pkg::cfg_t  cfg_next;
    espml_pkg::cmd_t  cmd;
    espml_pkg::stat_t stat;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                espml_pkg::REG_TARGET_RPM:  cfg_next.target_rpm      = cfg_wdata[15:0];
                espml_pkg::REG_PROP_GAIN:   cfg_next.prop_gain       = cfg_wdata;
                espml_pkg::REG_INTEG_GAIN:  cfg_next.integ_gain      = cfg_wdata;
                espml_pkg::REG_DERIV_GAIN:  cfg_next.deriv_gain      = cfg_wdata;
                espml_pkg::REG_INTEG_LIMIT: cfg_next.integ_limit     = cfg_wdata[7:0];
                espml_pkg::REG_EMA_ALPHA:   cfg_next.ema_alpha       = cfg_wdata[8:0];
                espml_pkg::REG_STILL_THR:   cfg_next.still_threshold = cfg_wdata[11:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_rpm      <= 16'd150;
            cfg_reg.prop_gain       <= 32'd98784248;
            cfg_reg.integ_gain      <= 32'd281475;
            cfg_reg.deriv_gain      <= 32'd322122547;
            cfg_reg.integ_limit     <= 8'd50;
            cfg_reg.ema_alpha       <= 9'd154;
            cfg_reg.still_threshold <= 12'd10;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    espml_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_ready  (sample.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    espml_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .cmd        (cmd),
        .stat       (stat),
        .angle_raw  (sample.angle_raw),
        .elapsed_us (sample.elapsed_us),
        .motor_duty (result.motor_duty),
        .speed_rpm  (result.speed_rpm)
    );

endmodule

// ----- rtl/espml_dp.sv -----
// Datapath: shared multiplier, serial divider, speed filter and PID state.
module espml_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  espml_pkg::cfg_t               cfg,
    input  espml_pkg::cmd_t               cmd,
    output espml_pkg::stat_t              stat,
    input  logic [espml_pkg::ANGLE_W-1:0] angle_raw,
    input  logic [espml_pkg::DT_W-1:0]    elapsed_us,
    output logic [espml_pkg::DUTY_W-1:0]  motor_duty,
    output logic [espml_pkg::SPEED_W-1:0] speed_rpm
);

    logic [espml_pkg::ANGLE_W-1:0]        ang_reg;
    logic [espml_pkg::DT_W-1:0]           dt_reg;
    logic [espml_pkg::ANGLE_W-1:0]        last_angle_reg;
    logic [espml_pkg::SPEED_W-1:0]        last_speed_reg;
    logic signed [espml_pkg::INTEG_W-1:0] integral_reg;
    logic signed [espml_pkg::ERR_W-1:0]   last_error_reg;
    logic [espml_pkg::DUTY_W-1:0]         duty_reg;
    logic signed [espml_pkg::INTEG_W-1:0] integ_new_reg;
    logic [espml_pkg::SPEED_W-1:0]        speed_reg;
    logic                                 still_reg;
    logic [24:0]                          ema_acc_reg;
    logic signed [espml_pkg::PROD_W-1:0]  prod_reg;
    logic signed [espml_pkg::SUM_W-1:0]   sum_reg;
    logic                                 dneg_reg;
    logic [espml_pkg::DT_W-1:0]           rem_reg;
    logic [espml_pkg::DIV_W-1:0]          quo_reg;
    logic [espml_pkg::DUTY_W-1:0]         out_duty_reg;
    logic [espml_pkg::SPEED_W-1:0]        out_speed_reg;

    logic [espml_pkg::ANGLE_W-1:0]        delta;
    logic [espml_pkg::ANGLE_W-1:0]        diff;
    logic [8:0]                           alpha;
    logic [8:0]                           beta;
    logic [espml_pkg::SPEED_W-1:0]        raw;
    logic signed [espml_pkg::ERR_W-1:0]   err;
    logic signed [espml_pkg::ERR_W:0]     derr;
    logic signed [espml_pkg::OP_W-1:0]    op_a;
    logic signed [espml_pkg::OP_W-1:0]    op_b;
    logic signed [espml_pkg::PROD_W-1:0]  product;
    logic [espml_pkg::DT_W-1:0]           divisor;
    logic [espml_pkg::DT_W:0]             shifted;
    logic                                 qbit;
    logic [24:0]                          ema_sum;
    logic signed [41:0]                   integ_sum;
    logic signed [espml_pkg::INTEG_W-1:0] integ_sat;
    logic signed [63:0]                   i_prod;
    logic signed [47:0]                   i_trunc;
    logic signed [espml_pkg::SUM_W-1:0]   i_ext;
    logic signed [espml_pkg::SUM_W-1:0]   i_lim;
    logic signed [espml_pkg::SUM_W-1:0]   i_term;
    logic signed [espml_pkg::PROD_W-1:0]  d_mag;
    logic signed [espml_pkg::SUM_W-1:0]   d_term;
    logic [espml_pkg::DUTY_W-1:0]         whole;

    assign delta   = last_angle_reg - ang_reg;
    assign diff    = (ang_reg > last_angle_reg) ? (ang_reg - last_angle_reg) : delta;
    assign stat.still = (diff < cfg.still_threshold);
    assign alpha   = (cfg.ema_alpha > 9'd256) ? 9'd256 : cfg.ema_alpha;
    assign beta    = 9'd256 - alpha;
    assign raw     = (|quo_reg[25:16]) ? 16'hFFFF : quo_reg[15:0];
    assign err     = $signed({1'b0, cfg.target_rpm}) - $signed({1'b0, speed_reg});
    assign derr    = 18'(err) - 18'(last_error_reg);
    assign divisor = (dt_reg == '0) ? 24'd1 : dt_reg;

    always_comb
    begin
        unique case (cmd.mul_sel)
            espml_pkg::MUL_SCALE:
            begin
                op_a = $signed(33'(delta));
                op_b = $signed(33'(espml_pkg::RPM_SCALE));
            end
            espml_pkg::MUL_ALPHA:
            begin
                op_a = $signed(33'(alpha));
                op_b = $signed(33'(raw));
            end
            espml_pkg::MUL_BETA:
            begin
                op_a = $signed(33'(beta));
                op_b = $signed(33'(last_speed_reg));
            end
            espml_pkg::MUL_INTEG:
            begin
                op_a = 33'(err);
                op_b = $signed(33'(dt_reg));
            end
            espml_pkg::MUL_PROP:
            begin
                op_a = $signed(33'(cfg.prop_gain));
                op_b = 33'(err);
            end
            espml_pkg::MUL_IGAIN:
            begin
                op_a = $signed(33'(cfg.integ_gain));
                op_b = 33'(integ_new_reg);
            end
            espml_pkg::MUL_DERIV:
            begin
                op_a = $signed(33'(cfg.deriv_gain));
                op_b = 33'(derr);
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign product = op_a * op_b;

    assign shifted = {rem_reg, quo_reg[espml_pkg::DIV_W-1]};
    assign qbit    = (shifted >= {1'b0, divisor});

    assign ema_sum = ema_acc_reg + prod_reg[24:0];

    assign integ_sum = 42'(integral_reg) + prod_reg[41:0];
    always_comb
    begin
        if (integ_sum > 42'sd2147483647)
            integ_sat = 32'sh7FFFFFFF;
        else if (integ_sum < -42'sd2147483648)
            integ_sat = 32'sh80000000;
        else
            integ_sat = integ_sum[31:0];
    end

    assign i_prod  = prod_reg[63:0];
    assign i_trunc = i_prod[63] ? 48'((i_prod + 64'sd65535) >>> 16) : 48'(i_prod >>> 16);
    assign i_ext   = 56'(i_trunc);
    assign i_lim   = $signed({16'd0, cfg.integ_limit, 32'd0});
    always_comb
    begin
        if (i_ext > i_lim)
            i_term = i_lim;
        else if (i_ext < -i_lim)
            i_term = -i_lim;
        else
            i_term = i_ext;
    end

    assign d_mag  = prod_reg[espml_pkg::PROD_W-1] ? -prod_reg : prod_reg;
    assign d_term = dneg_reg ? -$signed(56'(quo_reg)) : $signed(56'(quo_reg));

    always_comb
    begin
        if (sum_reg[espml_pkg::SUM_W-1])
            whole = '0;
        else if (|sum_reg[54:40])
            whole = 8'hFF;
        else
            whole = sum_reg[39:32];
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= product;
        if (cmd.load_in)
        begin
            ang_reg <= angle_raw;
            dt_reg  <= elapsed_us;
        end
        if (cmd.check)
        begin
            still_reg <= stat.still;
            if (stat.still)
                speed_reg <= '0;
        end
        if (cmd.div_load_spd)
        begin
            rem_reg <= '0;
            quo_reg <= {prod_reg[25:0], 24'd0};
        end
        else if (cmd.div_load_d)
        begin
            rem_reg  <= '0;
            quo_reg  <= d_mag[espml_pkg::DIV_W-1:0];
            dneg_reg <= prod_reg[espml_pkg::PROD_W-1];
        end
        else if (cmd.div_step)
        begin
            rem_reg <= qbit ? 24'(shifted - {1'b0, divisor}) : shifted[23:0];
            quo_reg <= {quo_reg[espml_pkg::DIV_W-2:0], qbit};
        end
        if (cmd.ema_b)
            ema_acc_reg <= prod_reg[24:0];
        if (cmd.ema_c)
            speed_reg <= ema_sum[23:8];
        if (cmd.int_latch)
            integ_new_reg <= integ_sat;
        if (cmd.p_latch)
            sum_reg <= $signed({16'd0, duty_reg, 32'd0}) + prod_reg[55:0];
        else if (cmd.i_add)
            sum_reg <= sum_reg + i_term;
        else if (cmd.d_add)
            sum_reg <= sum_reg + d_term;
        if (cmd.commit)
        begin
            out_duty_reg  <= whole;
            out_speed_reg <= speed_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_angle_reg <= '0;
            last_speed_reg <= '0;
            integral_reg   <= '0;
            last_error_reg <= '0;
            duty_reg       <= '0;
        end
        else if (cmd.commit)
        begin
            integral_reg   <= integ_new_reg;
            last_error_reg <= err;
            duty_reg       <= whole;
            if (!still_reg)
            begin
                last_angle_reg <= ang_reg;
                last_speed_reg <= speed_reg;
            end
        end
    end

    assign motor_duty = out_duty_reg;
    assign speed_rpm  = out_speed_reg;

endmodule

// ----- rtl/espml_ctrl.sv -----
// Controller: sequences multiplier, divider and accumulate steps for one item.
module espml_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  espml_pkg::stat_t  stat,
    output espml_pkg::cmd_t   cmd
);

    espml_pkg::state_t             state_reg;
    espml_pkg::state_t             state_next;
    logic [espml_pkg::CNT_W-1:0]   cnt_reg;
    logic [espml_pkg::CNT_W-1:0]   cnt_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic                          slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            espml_pkg::S_IDLE:
                if (in_valid)
                    state_next = espml_pkg::S_CHECK;
            espml_pkg::S_CHECK:
                state_next = stat.still ? espml_pkg::S_MUL_INT : espml_pkg::S_DLOAD_SPD;
            espml_pkg::S_DLOAD_SPD:
            begin
                cnt_next   = espml_pkg::SPD_DIV_STEPS;
                state_next = espml_pkg::S_DIV_SPD;
            end
            espml_pkg::S_DIV_SPD:
            begin
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == espml_pkg::CNT_W'(1))
                    state_next = espml_pkg::S_EMA_A;
            end
            espml_pkg::S_EMA_A:   state_next = espml_pkg::S_EMA_B;
            espml_pkg::S_EMA_B:   state_next = espml_pkg::S_EMA_C;
            espml_pkg::S_EMA_C:   state_next = espml_pkg::S_MUL_INT;
            espml_pkg::S_MUL_INT: state_next = espml_pkg::S_INT;
            espml_pkg::S_INT:     state_next = espml_pkg::S_P;
            espml_pkg::S_P:       state_next = espml_pkg::S_I;
            espml_pkg::S_I:       state_next = espml_pkg::S_DLOAD_D;
            espml_pkg::S_DLOAD_D:
            begin
                cnt_next   = espml_pkg::D_DIV_STEPS;
                state_next = espml_pkg::S_DIV_D;
            end
            espml_pkg::S_DIV_D:
            begin
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == espml_pkg::CNT_W'(1))
                    state_next = espml_pkg::S_D;
            end
            espml_pkg::S_D:       state_next = espml_pkg::S_FIN;
            espml_pkg::S_FIN:
                if (slot_free)
                    state_next = espml_pkg::S_IDLE;
            default:              state_next = espml_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.mul_sel = espml_pkg::MUL_SCALE;
        in_ready    = 1'b0;
        unique case (state_reg)
            espml_pkg::S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            espml_pkg::S_CHECK:
            begin
                cmd.check   = 1'b1;
                cmd.mul_sel = espml_pkg::MUL_SCALE;
            end
            espml_pkg::S_DLOAD_SPD: cmd.div_load_spd = 1'b1;
            espml_pkg::S_DIV_SPD:   cmd.div_step = 1'b1;
            espml_pkg::S_EMA_A:     cmd.mul_sel = espml_pkg::MUL_ALPHA;
            espml_pkg::S_EMA_B:
            begin
                cmd.ema_b   = 1'b1;
                cmd.mul_sel = espml_pkg::MUL_BETA;
            end
            espml_pkg::S_EMA_C:     cmd.ema_c = 1'b1;
            espml_pkg::S_MUL_INT:   cmd.mul_sel = espml_pkg::MUL_INTEG;
            espml_pkg::S_INT:
            begin
                cmd.int_latch = 1'b1;
                cmd.mul_sel   = espml_pkg::MUL_PROP;
            end
            espml_pkg::S_P:
            begin
                cmd.p_latch = 1'b1;
                cmd.mul_sel = espml_pkg::MUL_IGAIN;
            end
            espml_pkg::S_I:
            begin
                cmd.i_add   = 1'b1;
                cmd.mul_sel = espml_pkg::MUL_DERIV;
            end
            espml_pkg::S_DLOAD_D:   cmd.div_load_d = 1'b1;
            espml_pkg::S_DIV_D:     cmd.div_step = 1'b1;
            espml_pkg::S_D:         cmd.d_add = 1'b1;
            espml_pkg::S_FIN:       cmd.commit = slot_free;
            default:                cmd = '0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= espml_pkg::S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_commit_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || out_ready))
        else $error("result committed over a waiting item");

    a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == espml_pkg::S_CHECK))
        else $error("accepted item not started");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == espml_pkg::S_DIV_SPD || state_reg == espml_pkg::S_DIV_D)
            |-> (cnt_reg != '0))
        else $error("divider step count ran out");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.commit))
        else $error("result valid without commit");

endmodule
